### hdl/rre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_pkg
// Shared constants and seed tables of the reciprocal and reciprocal
// square-root estimate block.
// ----------------------------------------------------------------------------
package rre_pkg;

   // operation select codes
   localparam logic FUNC_RCP = 1'b0;
   localparam logic FUNC_RSQ = 1'b1;

   // double precision bit patterns
   localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [10:0] EXP_ONES  = 11'h7FF;

   // exponent constants
   localparam logic [12:0] RSQ_EXP_SUB = 13'd1021;
   localparam logic [11:0] RSQ_EXP_TOP = 12'd1023;
   localparam logic [11:0] RCP_EXP_TOP = 12'd2045;

   // reciprocal square-root offsets, indexed by exponent lsb and top mantissa bits
   function automatic logic [25:0] rsq_off(input logic [4:0] idx);
      logic [25:0] v;
      unique case (idx)
         5'd0:  v = 26'h1a7e800;
         5'd1:  v = 26'h17cb800;
         5'd2:  v = 26'h1552800;
         5'd3:  v = 26'h130c000;
         5'd4:  v = 26'h10f2000;
         5'd5:  v = 26'h0eff000;
         5'd6:  v = 26'h0d2e000;
         5'd7:  v = 26'h0b7c000;
         5'd8:  v = 26'h09e5000;
         5'd9:  v = 26'h0867000;
         5'd10: v = 26'h06ff000;
         5'd11: v = 26'h05ab800;
         5'd12: v = 26'h046a000;
         5'd13: v = 26'h0339800;
         5'd14: v = 26'h0218800;
         5'd15: v = 26'h0105800;
         5'd16: v = 26'h3ffa000;
         5'd17: v = 26'h3c29000;
         5'd18: v = 26'h38aa000;
         5'd19: v = 26'h3572000;
         5'd20: v = 26'h3279000;
         5'd21: v = 26'h2fb7000;
         5'd22: v = 26'h2d26000;
         5'd23: v = 26'h2ac0000;
         5'd24: v = 26'h2881000;
         5'd25: v = 26'h2665000;
         5'd26: v = 26'h2468000;
         5'd27: v = 26'h2287000;
         5'd28: v = 26'h20c1000;
         5'd29: v = 26'h1f12000;
         5'd30: v = 26'h1d79000;
         5'd31: v = 26'h1bf4000;
         default: v = '0;
      endcase
      return v;
   endfunction

   // reciprocal square-root slopes
   function automatic logic [10:0] rsq_stp(input logic [4:0] idx);
      logic [10:0] v;
      unique case (idx)
         5'd0:  v = 11'h568;
         5'd1:  v = 11'h4f3;
         5'd2:  v = 11'h48d;
         5'd3:  v = 11'h435;
         5'd4:  v = 11'h3e7;
         5'd5:  v = 11'h3a2;
         5'd6:  v = 11'h365;
         5'd7:  v = 11'h32e;
         5'd8:  v = 11'h2fc;
         5'd9:  v = 11'h2d0;
         5'd10: v = 11'h2a8;
         5'd11: v = 11'h283;
         5'd12: v = 11'h261;
         5'd13: v = 11'h243;
         5'd14: v = 11'h226;
         5'd15: v = 11'h20b;
         5'd16: v = 11'h7a4;
         5'd17: v = 11'h700;
         5'd18: v = 11'h670;
         5'd19: v = 11'h5f2;
         5'd20: v = 11'h584;
         5'd21: v = 11'h524;
         5'd22: v = 11'h4cc;
         5'd23: v = 11'h47e;
         5'd24: v = 11'h43a;
         5'd25: v = 11'h3fa;
         5'd26: v = 11'h3c2;
         5'd27: v = 11'h38e;
         5'd28: v = 11'h35e;
         5'd29: v = 11'h332;
         5'd30: v = 11'h30a;
         5'd31: v = 11'h2e6;
         default: v = '0;
      endcase
      return v;
   endfunction

   // reciprocal offsets, indexed by top mantissa bits
   function automatic logic [22:0] rcp_off(input logic [4:0] idx);
      logic [22:0] v;
      unique case (idx)
         5'd0:  v = 23'h7ff800;
         5'd1:  v = 23'h783800;
         5'd2:  v = 23'h70ea00;
         5'd3:  v = 23'h6a0800;
         5'd4:  v = 23'h638800;
         5'd5:  v = 23'h5d6200;
         5'd6:  v = 23'h579000;
         5'd7:  v = 23'h520800;
         5'd8:  v = 23'h4cc800;
         5'd9:  v = 23'h47ca00;
         5'd10: v = 23'h430800;
         5'd11: v = 23'h3e8000;
         5'd12: v = 23'h3a2c00;
         5'd13: v = 23'h360800;
         5'd14: v = 23'h321400;
         5'd15: v = 23'h2e4a00;
         5'd16: v = 23'h2aa800;
         5'd17: v = 23'h272c00;
         5'd18: v = 23'h23d600;
         5'd19: v = 23'h209e00;
         5'd20: v = 23'h1d8800;
         5'd21: v = 23'h1a9000;
         5'd22: v = 23'h17ae00;
         5'd23: v = 23'h14f800;
         5'd24: v = 23'h124400;
         5'd25: v = 23'h0fbe00;
         5'd26: v = 23'h0d3800;
         5'd27: v = 23'h0ade00;
         5'd28: v = 23'h088400;
         5'd29: v = 23'h065000;
         5'd30: v = 23'h041c00;
         5'd31: v = 23'h020c00;
         default: v = '0;
      endcase
      return v;
   endfunction

   // reciprocal slopes
   function automatic logic [9:0] rcp_stp(input logic [4:0] idx);
      logic [9:0] v;
      unique case (idx)
         5'd0:  v = 10'h3e1;
         5'd1:  v = 10'h3a7;
         5'd2:  v = 10'h371;
         5'd3:  v = 10'h340;
         5'd4:  v = 10'h313;
         5'd5:  v = 10'h2ea;
         5'd6:  v = 10'h2c4;
         5'd7:  v = 10'h2a0;
         5'd8:  v = 10'h27f;
         5'd9:  v = 10'h261;
         5'd10: v = 10'h245;
         5'd11: v = 10'h22a;
         5'd12: v = 10'h212;
         5'd13: v = 10'h1fb;
         5'd14: v = 10'h1e5;
         5'd15: v = 10'h1d1;
         5'd16: v = 10'h1be;
         5'd17: v = 10'h1ac;
         5'd18: v = 10'h19b;
         5'd19: v = 10'h18b;
         5'd20: v = 10'h17c;
         5'd21: v = 10'h16e;
         5'd22: v = 10'h15b;
         5'd23: v = 10'h15b;
         5'd24: v = 10'h143;
         5'd25: v = 10'h143;
         5'd26: v = 10'h12d;
         5'd27: v = 10'h12d;
         5'd28: v = 10'h11a;
         5'd29: v = 10'h11a;
         5'd30: v = 10'h108;
         5'd31: v = 10'h106;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hdl/rre_rsq_est.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_rsq_est
// Reciprocal square-root estimate: table seed, one 11x11 multiply, special
// operands.
// ----------------------------------------------------------------------------
module rre_rsq_est
   import rre_pkg::*;
(
   input  logic [63:0] operand_bits,
   output logic [63:0] result_bits
);

   logic        sign;
   logic [10:0] exp_f;
   logic [51:0] mant;
   logic [4:0]  idx;
   logic [10:0] mul;
   logic [21:0] prod;
   logic [31:0] val;
   logic [12:0] exp_diff;
   logic [11:0] new_exp;
   logic [37:0] hi_sum;

   assign sign  = operand_bits[63];
   assign exp_f = operand_bits[62:52];
   assign mant  = operand_bits[51:0];
   assign idx   = operand_bits[52:48];
   assign mul   = operand_bits[47:37];

   // interpolate between table points
   assign prod = {11'b0, rsq_stp(idx)} * {11'b0, mul};
   assign val  = {6'b0, rsq_off(idx)} - {10'b0, prod};

   // halved exponent, only the low 12 bits of the wrapped value survive
   assign exp_diff = {2'b0, exp_f} - RSQ_EXP_SUB;
   assign new_exp  = RSQ_EXP_TOP - exp_diff[12:1];

   // seed may carry into exponent and sign
   assign hi_sum = {new_exp, 26'b0} + {6'b0, val};

   // special operands first
   always_comb begin
      priority if (operand_bits[62:0] == 63'b0) begin
         result_bits = (operand_bits & SIGN_BIT) | EXP_MASK;
      end else if (exp_f == EXP_ONES) begin
         if (mant == 52'b0) begin
            result_bits = sign ? QNAN_BITS : 64'b0;
         end else begin
            result_bits = operand_bits;
         end
      end else if (sign) begin
         result_bits = QNAN_BITS;
      end else begin
         result_bits = {hi_sum, 26'b0};
      end
   end

endmodule

### hdl/rre_rcp_est.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_rcp_est
// Reciprocal estimate: table seed, one 10x10 multiply with rounding,
// special operands.
// ----------------------------------------------------------------------------
module rre_rcp_est
   import rre_pkg::*;
(
   input  logic [63:0] operand_bits,
   output logic [63:0] result_bits
);

   logic        sign;
   logic [10:0] exp_f;
   logic [51:0] mant;
   logic [4:0]  idx;
   logic [9:0]  mul;
   logic [19:0] prod;
   logic [20:0] prod_rnd;
   logic [31:0] val;
   logic [11:0] new_exp;
   logic [11:0] top_bits;
   logic [34:0] hi_sum;

   assign sign  = operand_bits[63];
   assign exp_f = operand_bits[62:52];
   assign mant  = operand_bits[51:0];
   assign idx   = operand_bits[51:47];
   assign mul   = operand_bits[46:37];

   // rounded half step
   assign prod     = {10'b0, rcp_stp(idx)} * {10'b0, mul};
   assign prod_rnd = {1'b0, prod} + 21'd1;
   assign val      = {9'b0, rcp_off(idx)} - {12'b0, prod_rnd[20:1]};

   // negated exponent, bit 11 of the wrapped value merges into the sign
   assign new_exp  = RCP_EXP_TOP - {1'b0, exp_f};
   assign top_bits = {new_exp[11] | sign, new_exp[10:0]};
   assign hi_sum   = {top_bits, 23'b0} + {3'b0, val};

   // special operands first
   always_comb begin
      priority if (exp_f == 11'b0) begin
         result_bits = operand_bits | EXP_MASK;
      end else if (exp_f == EXP_ONES) begin
         if (mant == 52'b0) begin
            result_bits = sign ? SIGN_BIT : 64'b0;
         end else begin
            result_bits = operand_bits;
         end
      end else begin
         result_bits = {hi_sum, 29'b0};
      end
   end

endmodule

### hdl/reciprocal_and_rsqrt_estimate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reciprocal_and_rsqrt_estimate
// Table based reciprocal and reciprocal square-root estimates of a double.
// ----------------------------------------------------------------------------
// An item carries an operation select (0 reciprocal, 1 reciprocal square
// root) and a raw double. It is captured in an input register, the estimate
// is formed by a 32-entry seed table and one short multiply, and the 64-bit
// result is held in an output register, whose valid flag is rsp_valid;
// one item is accepted every cycle while rsp_ready stays high. During a
// result stall the input register takes one more item, and req_ready follows
// rsp_ready in the same cycle once both registers are full, so draining
// resumes without a bubble.
module reciprocal_and_rsqrt_estimate
   import rre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [63:0] req_operand_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_bits
);

   logic        in_vld_ff, in_vld_in;
   logic        in_func_ff;
   logic [63:0] in_op_ff;
   logic        out_vld_ff, out_vld_in;
   logic [63:0] out_res_ff;
   logic [63:0] rsq_res;
   logic [63:0] rcp_res;
   logic [63:0] est_res;
   logic        out_take;
   logic        in_take;

   // pipeline handshakes
   assign out_take  = !out_vld_ff || rsp_ready;
   assign req_ready = !in_vld_ff || out_take;
   assign in_take   = req_valid && req_ready;

   assign in_vld_in  = in_take || (in_vld_ff && !out_take);
   assign out_vld_in = out_take ? in_vld_ff : out_vld_ff;

   // estimate units
   rre_rsq_est u_rsq (
      .operand_bits (in_op_ff),
      .result_bits  (rsq_res)
   );

   rre_rcp_est u_rcp (
      .operand_bits (in_op_ff),
      .result_bits  (rcp_res)
   );

   assign est_res = (in_func_ff == FUNC_RSQ) ? rsq_res : rcp_res;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_func_ff <= req_func;
         in_op_ff   <= req_operand_bits;
      end
      if (out_take && in_vld_ff) begin
         out_res_ff <= est_res;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_bits = out_res_ff;

   // a taken result always frees the input side
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while result side drains");

   // an accepted item moves from the input register to the output when rsp_ready is high while it waits there
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted item did not reach the output");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule
